### sv/lbb_pkg.sv
package lbb_pkg;

	localparam int unsigned DUTY_W = 15;
	localparam int unsigned MODE_W = 8;
	localparam int unsigned CNT_W  = 3;

	localparam logic [DUTY_W-1:0] PERIOD_TOP_RST = 15'd20000;
	localparam logic [DUTY_W-1:0] DUTY_STEP_RST  = 15'd1000;

	// Register word indexes on the configuration port
	localparam logic REG_PERIOD_TOP = 1'b0;
	localparam logic REG_DUTY_STEP  = 1'b1;

	// Request kinds
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_SET  = 1'b1;

	// Mode codes
	localparam logic [MODE_W-1:0] MODE_OFF          = 8'h00;
	localparam logic [MODE_W-1:0] MODE_BREATH_BLUE  = 8'h0D;
	localparam logic [MODE_W-1:0] MODE_BREATH_RED   = 8'hD0;
	localparam logic [MODE_W-1:0] MODE_BREATH_ALT   = 8'hDD;
	localparam logic [MODE_W-1:0] MODE_SOLID_BLUE   = 8'h01;
	localparam logic [MODE_W-1:0] MODE_SOLID_RED    = 8'h10;
	localparam logic [MODE_W-1:0] MODE_SOLID_BOTH   = 8'h11;
	localparam logic [MODE_W-1:0] MODE_BLINK_BLUE   = 8'h0C;
	localparam logic [MODE_W-1:0] MODE_BLINK_RED    = 8'hC0;
	localparam logic [MODE_W-1:0] MODE_BLINK_BOTH   = 8'hCC;

	// Alternating breath swaps colour once this many turns are done
	localparam logic [MODE_W-1:0] ALT_TURNS = 8'd3;
	// Blink burst: off ticks after the on tick minus one, and burst length
	localparam logic [CNT_W-1:0]  BLINK_OFF_LAST = 3'd3;
	localparam logic [CNT_W-1:0]  BLINK_CYCLES   = 3'd4;

	typedef struct packed {
		logic stop;   // burst finished: stop the PWM
		logic lit;    // on tick of the burst
	} blink_status_t;

endpackage

### sv/lbb_blink.sv
module lbb_blink
	import lbb_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	output blink_status_t status
);

	logic             on_done_q;
	logic [CNT_W-1:0] off_q;
	logic [CNT_W-1:0] cycle_q;

	logic             on_done_n;
	logic [CNT_W-1:0] off_n;
	logic [CNT_W-1:0] cycle_n;

	always_comb begin
		status    = '0;
		on_done_n = on_done_q;
		off_n     = off_q;
		cycle_n   = cycle_q;
		priority if (cycle_q >= BLINK_CYCLES) begin
			status.stop = 1'b1;
			cycle_n     = '0;
		end else if (!on_done_q) begin
			status.lit = 1'b1;
			on_done_n  = 1'b1;
			off_n      = '0;
		end else if (off_q >= BLINK_OFF_LAST) begin
			off_n     = '0;
			on_done_n = 1'b0;
			cycle_n   = cycle_q + CNT_W'(1);
		end else begin
			off_n = off_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_done_q <= 1'b0;
			off_q     <= '0;
			cycle_q   <= '0;
		end else if (step) begin
			on_done_q <= on_done_n;
			off_q     <= off_n;
			cycle_q   <= cycle_n;
		end
	end

endmodule

### sv/led_breath_blink_pwm_controller_top.sv
// Latency: a result is offered in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; the state update is a
// single pass of logic from the held state to the result register, which also acts
// as the output stage, so a new request is taken only when it is empty or draining.
// Reset (arst_n low, asynchronous): levels dark at 20000, mode off, all
// breath and blink counters cleared, registers back to 20000 and 1000.
module led_breath_blink_pwm_controller_top
	import lbb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [MODE_W-1:0] new_mode,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DUTY_W-1:0] blue_duty,
	output logic [DUTY_W-1:0] red_duty,
	output logic              pwm_running,
	output logic [MODE_W-1:0] mode_now,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	// Configuration registers
	logic [DUTY_W-1:0] period_q;
	logic [DUTY_W-1:0] step_q;

	// Controller state
	logic [DUTY_W-1:0] blue_q;
	logic [DUTY_W-1:0] red_q;
	logic [MODE_W-1:0] mode_q;
	logic              down_q;
	logic [MODE_W-1:0] turn_q;
	logic              red_sel_q;
	logic              running_q;

	// Result register
	logic              out_valid_q;
	logic [DUTY_W-1:0] blue_duty_q;
	logic [DUTY_W-1:0] red_duty_q;
	logic              running_out_q;
	logic [MODE_W-1:0] mode_out_q;

	logic accept;
	logic tick;

	// Next-state values
	logic [DUTY_W-1:0] blue_n;
	logic [DUTY_W-1:0] red_n;
	logic [MODE_W-1:0] mode_n;
	logic              down_n;
	logic [MODE_W-1:0] turn_n;
	logic              red_sel_n;
	logic              running_n;

	// Breath ramp datapath
	logic              use_red;
	logic              ramp_dir;
	logic [MODE_W-1:0] ramp_turn;
	logic [DUTY_W-1:0] ramp_in;
	logic [DUTY_W-1:0] ramp_out;
	logic [DUTY_W:0]   ramp_sum;
	logic              ramp_turned;

	// Blink engines, one per blink mode
	logic          step_blue;
	logic          step_red;
	logic          step_both;
	blink_status_t st_blue;
	blink_status_t st_red;
	blink_status_t st_both;

	// ------------------------------------------------------------------
	// Configuration port: word address in paddr[2], writes in access phase
	// ------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_TOP_RST;
			step_q   <= DUTY_STEP_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_PERIOD_TOP: period_q <= pwdata[DUTY_W-1:0];
				REG_DUTY_STEP:  step_q   <= pwdata[DUTY_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_PERIOD_TOP: prdata = {{(32-DUTY_W){1'b0}}, period_q};
			REG_DUTY_STEP:  prdata = {{(32-DUTY_W){1'b0}}, step_q};
			default:        prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Handshake: the result register is the output stage; take a new
	// request whenever it is empty or being drained this cycle
	// ------------------------------------------------------------------
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign tick     = accept && (req_type == REQ_TICK);

	assign step_blue = tick && (mode_q == MODE_BLINK_BLUE);
	assign step_red  = tick && (mode_q == MODE_BLINK_RED);
	assign step_both = tick && (mode_q == MODE_BLINK_BOTH);

	lbb_blink u_blink_blue (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step_blue),
		.status (st_blue)
	);

	lbb_blink u_blink_red (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step_red),
		.status (st_red)
	);

	lbb_blink u_blink_both (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step_both),
		.status (st_both)
	);

	// ------------------------------------------------------------------
	// Breath ramp. Alternating breath first swaps colour after three
	// turns, which also forces the ramp downwards; the ramp then works on
	// the selected channel with the possibly updated direction.
	// ------------------------------------------------------------------
	always_comb begin
		red_sel_n = red_sel_q;
		ramp_dir  = down_q;
		ramp_turn = turn_q;
		unique case (mode_q)
			MODE_BREATH_BLUE: use_red = 1'b0;
			MODE_BREATH_RED:  use_red = 1'b1;
			default: begin
				if (turn_q >= ALT_TURNS) begin
					red_sel_n = !red_sel_q;
					ramp_turn = '0;
					ramp_dir  = 1'b1;
				end
				use_red = red_sel_n;
			end
		endcase

		ramp_in     = use_red ? red_q : blue_q;
		ramp_sum    = {1'b0, ramp_in} + {1'b0, step_q};
		ramp_turned = 1'b0;
		if (ramp_dir) begin
			if (ramp_in >= step_q) begin
				ramp_out = ramp_in - step_q;
			end else begin
				// hit full brightness: turn upwards
				ramp_out    = '0;
				ramp_turned = 1'b1;
			end
		end else begin
			if (ramp_sum >= {1'b0, period_q}) begin
				// reached dark (or beyond): saturate and turn downwards
				ramp_out    = period_q;
				ramp_turned = 1'b1;
			end else begin
				ramp_out = ramp_sum[DUTY_W-1:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Next state for one accepted request
	// ------------------------------------------------------------------
	always_comb begin
		blue_n    = blue_q;
		red_n     = red_q;
		mode_n    = mode_q;
		down_n    = down_q;
		turn_n    = turn_q;
		running_n = running_q;

		if (req_type == REQ_SET) begin
			// any set request darkens both channels; nonzero starts playback
			mode_n    = new_mode;
			blue_n    = period_q;
			red_n     = period_q;
			running_n = (new_mode != MODE_OFF);
		end else begin
			unique case (mode_q)
				MODE_OFF: begin
					blue_n    = period_q;
					red_n     = period_q;
					running_n = 1'b0;
				end
				MODE_BREATH_BLUE, MODE_BREATH_RED, MODE_BREATH_ALT: begin
					down_n = ramp_turned ? !ramp_dir : ramp_dir;
					turn_n = ramp_turned ? ramp_turn + MODE_W'(1) : ramp_turn;
					if (use_red) begin
						red_n  = ramp_out;
						blue_n = period_q;
					end else begin
						blue_n = ramp_out;
						red_n  = period_q;
					end
				end
				MODE_SOLID_BLUE: begin
					blue_n = '0;
					red_n  = period_q;
				end
				MODE_SOLID_RED: begin
					blue_n = period_q;
					red_n  = '0;
				end
				MODE_SOLID_BOTH: begin
					blue_n = '0;
					red_n  = '0;
				end
				MODE_BLINK_BLUE: begin
					blue_n = st_blue.lit ? '0 : period_q;
					red_n  = period_q;
					if (st_blue.stop) begin
						mode_n    = MODE_OFF;
						running_n = 1'b0;
					end
				end
				MODE_BLINK_RED: begin
					blue_n = period_q;
					red_n  = st_red.lit ? '0 : period_q;
					if (st_red.stop) begin
						mode_n    = MODE_OFF;
						running_n = 1'b0;
					end
				end
				MODE_BLINK_BOTH: begin
					blue_n = st_both.lit ? '0 : period_q;
					red_n  = st_both.lit ? '0 : period_q;
					if (st_both.stop) begin
						mode_n    = MODE_OFF;
						running_n = 1'b0;
					end
				end
				default: ; // unknown code: hold everything
			endcase
		end
	end

	// ------------------------------------------------------------------
	// State registers: advance on every accepted request
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blue_q    <= PERIOD_TOP_RST;
			red_q     <= PERIOD_TOP_RST;
			mode_q    <= MODE_OFF;
			down_q    <= 1'b0;
			turn_q    <= '0;
			red_sel_q <= 1'b0;
			running_q <= 1'b0;
		end else if (accept) begin
			blue_q    <= blue_n;
			red_q     <= red_n;
			mode_q    <= mode_n;
			running_q <= running_n;
			// breath state moves only on breath ticks
			if (tick) begin
				down_q    <= down_n;
				turn_q    <= turn_n;
				if (mode_q == MODE_BREATH_ALT) begin
					red_sel_q <= red_sel_n;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result register: load on accept, drop when taken
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blue_duty_q   <= blue_n;
			red_duty_q    <= red_n;
			running_out_q <= running_n;
			mode_out_q    <= mode_n;
		end
	end

	assign out_valid   = out_valid_q;
	assign blue_duty   = blue_duty_q;
	assign red_duty    = red_duty_q;
	assign pwm_running = running_out_q;
	assign mode_now    = mode_out_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// playback runs exactly while a nonzero mode is held
	a_running_mode: assert property (@(posedge clk) disable iff (!arst_n)
		running_q == (mode_q != MODE_OFF))
		else $error("running flag disagrees with mode");

	// a set request takes its mode code in the next cycle
	a_set_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == REQ_SET) |=> (mode_q == $past(new_mode)))
		else $error("set request did not load mode");

	// an empty result stage never stalls the request side
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("request stalled with empty result stage");

endmodule

### tb/sv/tb_led_breath_blink_pwm_controller_top.sv
`timescale 1ns / 1ps

module tb_led_breath_blink_pwm_controller_top;
	import lbb_pkg::*;

	// Blink modes keep their own counters, one slot per mode
	localparam int BLINK_IX_BLUE = 0;
	localparam int BLINK_IX_RED  = 1;
	localparam int BLINK_IX_BOTH = 2;

	// A code with no meaning to the block: a tick leaves everything alone
	localparam logic [MODE_W-1:0] MODE_UNKNOWN = 8'hFF;

	localparam logic [DUTY_W-1:0] DARK = PERIOD_TOP_RST;
	localparam logic [DUTY_W-1:0] FULL = '0;

	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 92;

	typedef struct packed {
		logic [DUTY_W-1:0] blue;
		logic [DUTY_W-1:0] red;
		logic              running;
		logic [MODE_W-1:0] mode;
	} led_result_t;

	typedef struct {
		logic              kind;
		logic [MODE_W-1:0] code;
		logic              typed;
		led_result_t       res;
	} directed_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              req_type;
	logic [MODE_W-1:0] new_mode;
	logic              out_valid;
	logic              out_ready;
	logic [DUTY_W-1:0] blue_duty;
	logic [DUTY_W-1:0] red_duty;
	logic              pwm_running;
	logic [MODE_W-1:0] mode_now;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	// Typed expectation travels alongside the request, like its payload
	logic              item_typed;
	led_result_t       item_typed_res;

	// Predictor copy of the block: registers and state
	logic [DUTY_W-1:0] period_top_q;
	logic [DUTY_W-1:0] duty_step_q;
	logic [DUTY_W-1:0] blue_lvl;
	logic [DUTY_W-1:0] red_lvl;
	logic [MODE_W-1:0] cur_mode;
	logic              ramp_dn;
	logic [MODE_W-1:0] turns;
	logic              red_sel;
	logic              pwm_on;
	logic              blink_lit [3];
	logic [CNT_W-1:0]  blink_off [3];
	logic [CNT_W-1:0]  blink_cyc [3];

	led_result_t       results_due [$];
	led_result_t       due_res;
	led_result_t       pred_res;
	int                fault_count = 0;

	// Sender and receiver pacing
	int                burst_left = 0;
	bit                sender_on = 1'b0;
	int unsigned       ready_tick = 0;
	int unsigned       ready_style = 0;

	directed_row_t     directed_rows [DIRECTED_ROWS];
	logic [MODE_W-1:0] known_modes [10];

	led_breath_blink_pwm_controller_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.new_mode   (new_mode),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.blue_duty  (blue_duty),
		.red_duty   (red_duty),
		.pwm_running(pwm_running),
		.mode_now   (mode_now),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	task automatic clear_led_state();
		period_top_q = PERIOD_TOP_RST;
		duty_step_q  = DUTY_STEP_RST;
		blue_lvl     = PERIOD_TOP_RST;
		red_lvl      = PERIOD_TOP_RST;
		cur_mode     = MODE_OFF;
		ramp_dn      = 1'b0;
		turns        = '0;
		red_sel      = 1'b0;
		pwm_on       = 1'b0;
		for (int i = 0; i < 3; i++) begin
			blink_lit[i] = 1'b0;
			blink_off[i] = '0;
			blink_cyc[i] = '0;
		end
	endtask

	task automatic stop_playback();
		blue_lvl = period_top_q;
		red_lvl  = period_top_q;
		pwm_on   = 1'b0;
		cur_mode = MODE_OFF;
	endtask

	// One breath step on a level; a turn at either end flips the shared direction
	function automatic logic [DUTY_W-1:0] ramp_level(input logic [DUTY_W-1:0] lvl);
		logic [DUTY_W:0] sum;
		if (ramp_dn) begin
			if (lvl >= duty_step_q)
				return lvl - duty_step_q;
			turns   = turns + 8'd1;
			ramp_dn = 1'b0;
			return '0;
		end
		sum = {1'b0, lvl} + {1'b0, duty_step_q};
		if (sum >= {1'b0, period_top_q}) begin
			turns   = turns + 8'd1;
			ramp_dn = 1'b1;
			return period_top_q;
		end
		return sum[DUTY_W-1:0];
	endfunction

	task automatic breath_step();
		logic use_red;
		if (cur_mode == MODE_BREATH_BLUE) begin
			use_red = 1'b0;
		end else if (cur_mode == MODE_BREATH_RED) begin
			use_red = 1'b1;
		end else begin
			if (turns >= ALT_TURNS) begin
				red_sel = !red_sel;
				turns   = '0;
				ramp_dn = 1'b1;
			end
			use_red = red_sel;
		end
		if (use_red) begin
			red_lvl  = ramp_level(red_lvl);
			blue_lvl = period_top_q;
		end else begin
			blue_lvl = ramp_level(blue_lvl);
			red_lvl  = period_top_q;
		end
	endtask

	task automatic blink_step(input int ix, input logic blue_on, input logic red_on);
		if (blink_cyc[ix] >= BLINK_CYCLES) begin
			stop_playback();
			blink_cyc[ix] = '0;
		end else if (!blink_lit[ix]) begin
			blue_lvl      = blue_on ? FULL : period_top_q;
			red_lvl       = red_on ? FULL : period_top_q;
			blink_lit[ix] = 1'b1;
			blink_off[ix] = '0;
		end else begin
			blue_lvl = period_top_q;
			red_lvl  = period_top_q;
			if (blink_off[ix] >= BLINK_OFF_LAST) begin
				blink_off[ix] = '0;
				blink_lit[ix] = 1'b0;
				blink_cyc[ix] = blink_cyc[ix] + 3'd1;
			end else begin
				blink_off[ix] = blink_off[ix] + 3'd1;
			end
		end
	endtask

	task automatic advance_led_state(input logic kind, input logic [MODE_W-1:0] code,
			output led_result_t r);
		if (kind == REQ_SET) begin
			cur_mode = code;
			if (code != MODE_OFF) begin
				blue_lvl = period_top_q;
				red_lvl  = period_top_q;
				pwm_on   = 1'b1;
			end else begin
				stop_playback();
			end
		end else begin
			case (cur_mode)
				MODE_OFF: stop_playback();
				MODE_BREATH_BLUE, MODE_BREATH_RED, MODE_BREATH_ALT: breath_step();
				MODE_SOLID_BLUE: begin
					blue_lvl = FULL;
					red_lvl  = period_top_q;
				end
				MODE_SOLID_RED: begin
					red_lvl  = FULL;
					blue_lvl = period_top_q;
				end
				MODE_SOLID_BOTH: begin
					blue_lvl = FULL;
					red_lvl  = FULL;
				end
				MODE_BLINK_BLUE: blink_step(BLINK_IX_BLUE, 1'b1, 1'b0);
				MODE_BLINK_RED:  blink_step(BLINK_IX_RED, 1'b0, 1'b1);
				MODE_BLINK_BOTH: blink_step(BLINK_IX_BOTH, 1'b1, 1'b1);
				default: ;
			endcase
		end
		r.blue    = blue_lvl;
		r.red     = red_lvl;
		r.running = pwm_on;
		r.mode    = cur_mode;
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fault_count++;
		end
	endtask

	// Score the result side first, then log the request taken on this edge:
	// its result cannot show up before the next edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$error("result offered with no request outstanding");
					fault_count++;
				end else begin
					due_res = results_due.pop_front();
					check_field("blue_duty", due_res.blue, blue_duty);
					check_field("red_duty", due_res.red, red_duty);
					check_field("pwm_running", due_res.running, pwm_running);
					check_field("mode_now", due_res.mode, mode_now);
				end
			end
			if (in_valid && in_ready) begin
				advance_led_state(req_type, new_mode, pred_res);
				results_due.push_back(item_typed ? item_typed_res : pred_res);
			end
		end
	end

	// Receiver: switch stall style at random, from never stalling to
	// mostly stalling, with a fixed three-of-five pattern in between.
	always @(posedge clk) begin
		if (ready_tick % 48 == 0)
			ready_style = $urandom_range(0, 3);
		ready_tick++;
		case (ready_style)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (ready_tick % 5 < 3);
		endcase
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Offer one request, hold it until taken, then either carry straight on
	// with the burst or drop valid for a random gap.
	task automatic offer_request(input logic kind, input logic [MODE_W-1:0] code,
			input logic typed, input led_result_t typed_res);
		req_type       <= kind;
		new_mode       <= code;
		item_typed     <= typed;
		item_typed_res <= typed_res;
		in_valid       <= 1'b1;
		sender_on = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			sender_on = 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 16);
		end
	endtask

	// Hold off the sender until every outstanding result has been taken
	task automatic wait_results_drained();
		if (sender_on) begin
			in_valid <= 1'b0;
			sender_on = 1'b0;
		end
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write both registers back to back, keeping psel high between them
	task automatic load_registers(input logic [DUTY_W-1:0] top, input logic [DUTY_W-1:0] stp);
		psel   <= 1'b1;
		pwrite <= 1'b1;
		paddr  <= {REG_PERIOD_TOP, 2'b00};
		pwdata <= 32'(top);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		paddr   <= {REG_DUTY_STEP, 2'b00};
		pwdata  <= 32'(stp);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		period_top_q = top;
		duty_step_q  = stp;
	endtask

	function automatic directed_row_t mk_row(input logic kind, input logic [MODE_W-1:0] code,
			input logic typed, input logic [DUTY_W-1:0] b, input logic [DUTY_W-1:0] r,
			input logic run, input logic [MODE_W-1:0] m);
		directed_row_t row;
		row.kind        = kind;
		row.code        = code;
		row.typed       = typed;
		row.res.blue    = b;
		row.res.red     = r;
		row.res.running = run;
		row.res.mode    = m;
		return row;
	endfunction

	// Ticks to follow a mode set: at times long enough for breath to turn and swap
	// colour, and for a blink burst to run out and stop by itself.
	function automatic int tick_run(input logic [MODE_W-1:0] code);
		case (code)
			MODE_BREATH_BLUE, MODE_BREATH_RED, MODE_BREATH_ALT: return $urandom_range(6, 50);
			MODE_BLINK_BLUE, MODE_BLINK_RED, MODE_BLINK_BOTH:   return $urandom_range(8, 26);
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	initial begin
		logic [DUTY_W-1:0] top;
		logic [DUTY_W-1:0] stp;
		logic [MODE_W-1:0] code;
		int                sent;
		int                runs;

		arst_n         = 1'b0;
		in_valid       = 1'b0;
		req_type       = REQ_TICK;
		new_mode       = MODE_OFF;
		out_ready      = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		item_typed     = 1'b0;
		item_typed_res = '0;
		clear_led_state();

		known_modes = '{MODE_OFF, MODE_BREATH_BLUE, MODE_BREATH_RED, MODE_BREATH_ALT,
			MODE_SOLID_BLUE, MODE_SOLID_RED, MODE_SOLID_BOTH,
			MODE_BLINK_BLUE, MODE_BLINK_RED, MODE_BLINK_BOTH};

		// Directed walk at reset settings: every mode set, a tick in each,
		// an unknown code, and a tick while off straight after reset.
		directed_rows[0]  = mk_row(REQ_TICK, MODE_OFF, 1'b1, DARK, DARK, 1'b0, MODE_OFF);
		directed_rows[1]  = mk_row(REQ_SET, MODE_SOLID_BLUE, 1'b1, DARK, DARK, 1'b1,
			MODE_SOLID_BLUE);
		directed_rows[2]  = mk_row(REQ_TICK, MODE_OFF, 1'b1, FULL, DARK, 1'b1,
			MODE_SOLID_BLUE);
		directed_rows[3]  = mk_row(REQ_SET, MODE_SOLID_RED, 1'b1, DARK, DARK, 1'b1,
			MODE_SOLID_RED);
		directed_rows[4]  = mk_row(REQ_TICK, MODE_OFF, 1'b1, DARK, FULL, 1'b1, MODE_SOLID_RED);
		directed_rows[5]  = mk_row(REQ_SET, MODE_SOLID_BOTH, 1'b1, DARK, DARK, 1'b1,
			MODE_SOLID_BOTH);
		directed_rows[6]  = mk_row(REQ_TICK, MODE_OFF, 1'b1, FULL, FULL, 1'b1,
			MODE_SOLID_BOTH);
		directed_rows[7]  = mk_row(REQ_SET, MODE_BREATH_BLUE, 1'b1, DARK, DARK, 1'b1,
			MODE_BREATH_BLUE);
		directed_rows[8]  = mk_row(REQ_TICK, MODE_OFF, 1'b0, '0, '0, 1'b0, '0);
		directed_rows[9]  = mk_row(REQ_TICK, MODE_OFF, 1'b0, '0, '0, 1'b0, '0);
		directed_rows[10] = mk_row(REQ_SET, MODE_BREATH_RED, 1'b1, DARK, DARK, 1'b1,
			MODE_BREATH_RED);
		directed_rows[11] = mk_row(REQ_TICK, MODE_OFF, 1'b0, '0, '0, 1'b0, '0);
		directed_rows[12] = mk_row(REQ_TICK, MODE_OFF, 1'b0, '0, '0, 1'b0, '0);
		directed_rows[13] = mk_row(REQ_SET, MODE_BREATH_ALT, 1'b1, DARK, DARK, 1'b1,
			MODE_BREATH_ALT);
		directed_rows[14] = mk_row(REQ_TICK, MODE_OFF, 1'b0, '0, '0, 1'b0, '0);
		directed_rows[15] = mk_row(REQ_SET, MODE_BLINK_BLUE, 1'b1, DARK, DARK, 1'b1,
			MODE_BLINK_BLUE);
		directed_rows[16] = mk_row(REQ_TICK, MODE_OFF, 1'b1, FULL, DARK, 1'b1,
			MODE_BLINK_BLUE);
		directed_rows[17] = mk_row(REQ_TICK, MODE_OFF, 1'b1, DARK, DARK, 1'b1,
			MODE_BLINK_BLUE);
		directed_rows[18] = mk_row(REQ_SET, MODE_BLINK_RED, 1'b1, DARK, DARK, 1'b1,
			MODE_BLINK_RED);
		directed_rows[19] = mk_row(REQ_TICK, MODE_OFF, 1'b1, DARK, FULL, 1'b1, MODE_BLINK_RED);
		directed_rows[20] = mk_row(REQ_SET, MODE_BLINK_BOTH, 1'b1, DARK, DARK, 1'b1,
			MODE_BLINK_BOTH);
		directed_rows[21] = mk_row(REQ_TICK, MODE_OFF, 1'b1, FULL, FULL, 1'b1,
			MODE_BLINK_BOTH);
		directed_rows[22] = mk_row(REQ_SET, MODE_UNKNOWN, 1'b1, DARK, DARK, 1'b1, MODE_UNKNOWN);
		directed_rows[23] = mk_row(REQ_TICK, MODE_UNKNOWN, 1'b1, DARK, DARK, 1'b1,
			MODE_UNKNOWN);
		directed_rows[24] = mk_row(REQ_SET, MODE_OFF, 1'b1, DARK, DARK, 1'b0, MODE_OFF);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			offer_request(directed_rows[i].kind, directed_rows[i].code,
				directed_rows[i].typed, directed_rows[i].res);

		// Random phases. Each starts idle with fresh register values; the mode
		// and counters carry over, so lowering the top leaves levels above it.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_results_drained();
			case (ph)
				0: begin top = 15'd32767; stp = 15'd32767; end
				1: begin top = 15'd1;     stp = 15'd1;     end
				2: begin top = 15'd300;   stp = 15'd97;    end
				3: begin top = 15'd60;    stp = 15'd7;     end
				4: begin top = 15'd25;    stp = 15'd4;     end
				5: begin top = 15'd5000;  stp = 15'd32767; end
				6: begin
					top = DUTY_W'($urandom_range(1, 32767));
					stp = DUTY_W'($urandom_range(1, top));
				end
				default: begin top = PERIOD_TOP_RST; stp = DUTY_STEP_RST; end
			endcase
			load_registers(top, stp);

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) < 8) begin
					// Well-formed: set a mode, then let it run for a while
					runs = $urandom_range(0, 10);
					code = (runs == 10) ? MODE_W'($urandom) : known_modes[runs];
					offer_request(REQ_SET, code, 1'b0, '0);
					runs = tick_run(code);
					for (int t = 0; t < runs; t++)
						offer_request(REQ_TICK, MODE_W'($urandom), 1'b0, '0);
					sent += runs + 1;
				end else begin
					offer_request(1'($urandom_range(0, 1)), MODE_W'($urandom), 1'b0, '0);
					sent++;
				end
				// Now and then let the block run dry mid-phase
				if ($urandom_range(0, 39) == 0)
					wait_results_drained();
			end
		end

		wait_results_drained();
		repeat (10) @(posedge clk);
		if (fault_count == 0 && results_due.size() == 0)
			$display("led_breath_blink_pwm_controller_top regression: pass");
		else
			$display("led_breath_blink_pwm_controller_top regression: fail");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("led_breath_blink_pwm_controller_top regression: fail");
		$finish;
	end

endmodule
